FILE: rtl/core/gelu_grad_pkg.sv
// Package for the GELU gradient unit: coefficient table and fixed widths.
// No dependencies.
package gelu_grad_pkg;

    // Coefficient g(t) in unsigned Q1.16 at t = 0, 0.25, ... 5.0
    localparam int unsigned G_ENTRIES = 21;
    localparam int unsigned G_LAST    = G_ENTRIES - 1;
    localparam int unsigned G_W       = 17;
    localparam logic [G_W-1:0] G_ONE  = 17'd65536;

    typedef logic [G_W-1:0] t_coef;

    function automatic t_coef g_lookup(input logic [4:0] idx);
        t_coef v;
        case (idx)
            5'd0:  v = 17'd32768;
            5'd1:  v = 17'd45572;
            5'd2:  v = 17'd56852;
            5'd3:  v = 17'd65485;
            5'd4:  v = 17'd70996;
            5'd5:  v = 17'd73575;
            5'd6:  v = 17'd73890;
            5'd7:  v = 17'd72806;
            5'd8:  v = 17'd71122;
            5'd9:  v = 17'd69415;
            5'd10: v = 17'd68001;
            5'd11: v = 17'd66980;
            5'd12: v = 17'd66319;
            5'd13: v = 17'd65930;
            5'd14: v = 17'd65721;
            5'd15: v = 17'd65617;
            5'd16: v = 17'd65569;
            5'd17: v = 17'd65549;
            5'd18: v = 17'd65540;
            5'd19: v = 17'd65538;
            default: v = G_ONE;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/gelu_gradient_unit.sv
// GELU gradient unit top level: six-stage pipeline computing dx = dy * g(x).
// Depends on gelu_grad_pkg.
//
// Exact-erf GELU backward pass, one word per cycle while not stalled.
// g(x) = Phi(x) + x*phi(x) is linearly interpolated from a 21-entry table
// (step 0.25, up to 5.0), with g(-a) = 1 - g(a) for negative x. dx = dy*g
// rounded to nearest (ties up), then saturated; o_saturated flags a clip.
// The pipeline takes a word every cycle, and the stages advance together,
// whenever the output register is free or taken.
module gelu_gradient_unit #(
    parameter int FRAC_BITS  = 12,
    parameter int DATA_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_x_value,
    input  logic signed [DATA_WIDTH-1:0] i_upstream_grad,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_input_grad,
    output logic                         o_saturated
);
    import gelu_grad_pkg::*;

    localparam int SEG_SHIFT = FRAC_BITS - 2;
    localparam int AW        = DATA_WIDTH;          // |x| fits in DATA_WIDTH bits unsigned
    localparam int SEG_W     = AW - SEG_SHIFT;
    localparam int IW        = G_W + SEG_SHIFT + 1; // interpolation sum width
    localparam int CW        = G_W + 1;             // signed coefficient
    localparam int PW        = DATA_WIDTH + CW;     // product width
    localparam int RW        = PW - 16;             // after shift

    logic adv;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // Stage 1: magnitude, segment, fraction
    logic                    r1_neg;
    logic [AW-1:0]           r1_a;
    logic signed [DATA_WIDTH-1:0] r1_dy;
    logic [AW-1:0]           n1_a;
    assign n1_a = i_x_value[DATA_WIDTH-1] ? AW'(-i_x_value) : AW'(i_x_value);

    // Stage 2: table reads
    logic                    r2_neg, r2_big;
    logic [SEG_SHIFT-1:0]    r2_frac;
    t_coef                   r2_g0, r2_g1;
    logic signed [DATA_WIDTH-1:0] r2_dy;
    logic [SEG_W-1:0]        s1_seg;
    logic [4:0]              s1_idx;
    assign s1_seg = r1_a[AW-1:SEG_SHIFT];
    assign s1_idx = 5'(s1_seg);

    // Stage 3: interpolation products
    logic                    r3_neg, r3_big;
    logic [IW-1:0]           r3_m0, r3_m1;
    logic signed [DATA_WIDTH-1:0] r3_dy;
    logic [SEG_SHIFT:0]      span;
    assign span = (SEG_SHIFT+1)'(1) << SEG_SHIFT;

    // Stage 4: signed coefficient
    logic signed [CW-1:0]    r4_g;
    logic signed [DATA_WIDTH-1:0] r4_dy;
    logic [IW-1:0]           s3_sum;
    t_coef                   s3_g;
    assign s3_sum = r3_m0 + r3_m1;
    assign s3_g   = r3_big ? G_ONE : G_W'(s3_sum >> SEG_SHIFT);

    // Stage 5: product
    logic signed [PW-1:0]    r5_p;
    logic signed [PW-1:0]    s5_r;
    logic signed [RW-1:0]    s5_dx;
    logic signed [RW-1:0]    hi, lo;
    assign s5_r  = r5_p + PW'(32768);
    assign s5_dx = RW'(s5_r >>> 16);
    assign hi    = RW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    assign lo    = -hi - RW'(1);

    logic [4:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else if (adv) begin
            r_v     <= {r_v[3:0], i_valid};
            o_valid <= r_v[4];
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_neg  <= i_x_value[DATA_WIDTH-1];
            r1_a    <= n1_a;
            r1_dy   <= i_upstream_grad;

            r2_neg  <= r1_neg;
            r2_big  <= 32'(s1_seg) >= G_LAST;
            r2_frac <= r1_a[SEG_SHIFT-1:0];
            r2_g0   <= g_lookup(s1_idx);
            r2_g1   <= g_lookup(s1_idx + 5'd1);
            r2_dy   <= r1_dy;

            r3_neg  <= r2_neg;
            r3_big  <= r2_big;
            r3_m0   <= IW'(r2_g0) * IW'(span - (SEG_SHIFT+1)'(r2_frac));
            r3_m1   <= IW'(r2_g1) * IW'(r2_frac);
            r3_dy   <= r2_dy;

            r4_g    <= r3_neg ? CW'({1'b0, G_ONE}) - CW'({1'b0, s3_g})
                              : CW'({1'b0, s3_g});
            r4_dy   <= r3_dy;

            r5_p    <= PW'(r4_dy) * PW'(r4_g);

            if (s5_dx > hi) begin
                o_input_grad <= hi[DATA_WIDTH-1:0];
                o_saturated  <= 1'b1;
            end else if (s5_dx < lo) begin
                o_input_grad <= lo[DATA_WIDTH-1:0];
                o_saturated  <= 1'b1;
            end else begin
                o_input_grad <= s5_dx[DATA_WIDTH-1:0];
                o_saturated  <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // Output word holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_input_grad))
        else $error("output word changed under stall");
    // Word in the last stage moves to the output on an advancing cycle
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_v[4] |=> o_valid)
        else $error("word lost at last stage");
    // Saturated output is at a bound
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_input_grad == hi[DATA_WIDTH-1:0]
                                 || o_input_grad == lo[DATA_WIDTH-1:0])
        else $error("saturation flag without bound value");
`endif

endmodule

FILE: bench/tb.sv
// Testbench for gelu_gradient_unit: directed and random words checked against a
// behavioral GELU-gradient predictor. Depends on gelu_grad_pkg and the unit RTL.
module tb;
    import gelu_grad_pkg::*;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] dy;
    } t_word;

    typedef struct packed {
        logic signed [15:0] grad;
        logic               sat;
    } t_grad;

    // Coefficient table, unsigned Q1.16
    localparam int unsigned COEF[21] = '{
        32768, 45572, 56852, 65485, 70996, 73575, 73890, 72806,
        71122, 69415, 68001, 66980, 66319, 65930, 65721, 65617,
        65569, 65549, 65540, 65538, 65536};
    localparam int SEG_SHIFT = 10;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 100;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_x_value = '0;
    logic signed [15:0] i_upstream_grad = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_input_grad;
    logic               o_saturated;

    t_word  pending_words[$];
    t_grad  expected_grads[$];
    int     mismatches = 0;
    int     cycle_count = 0;
    int     send_gap = 0;
    int     recv_gap = 0;
    int     hold_off = 0;
    bit     stimulus_done = 1'b0;

    gelu_gradient_unit i_dut (.*);

    always #1 i_clk = ~i_clk;

    // Predicted dx and saturation flag for one word
    function automatic t_grad predict_grad(t_word w);
        longint ax, seg, frac, g, p, dx;
        t_grad  r;
        ax = (w.x < 0) ? -longint'(w.x) : longint'(w.x);
        seg = ax >> SEG_SHIFT;
        frac = ax & 1023;
        if (seg >= 20) g = 65536;
        else g = (longint'(COEF[seg]) * (1024 - frac) + longint'(COEF[seg + 1]) * frac)
                 >>> SEG_SHIFT;
        if (w.x < 0) g = 65536 - g;
        p = longint'(w.dy) * g + 32768;
        dx = p >>> 16;
        r.sat = 1'b0;
        if (dx > 32767) begin
            dx = 32767;
            r.sat = 1'b1;
        end else if (dx < -32768) begin
            dx = -32768;
            r.sat = 1'b1;
        end
        r.grad = dx[15:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Stimulus: directed extremes, then random words
    initial begin
        t_word w;
        logic signed [15:0] xs[10];
        xs = '{16'sh0000, 16'sh7fff, -16'sh8000, 16'sh4fff,
            16'sh5000, -16'sh5000, 16'sh0400, -16'sh0001, 16'sh13ff, 16'sh1800};
        foreach (xs[k]) begin
            w.x = xs[k];
            w.dy = (k % 2) ? 16'sh7fff : -16'sh8000;
            pending_words.push_back(w);
        end
        for (int k = 0; k < 8; k++) begin
            w.x = 16'sh1800 + 16'(k * 100);
            w.dy = (k % 2) ? 16'sh7fff : -16'sh8000;
            pending_words.push_back(w);
        end
        w.x = 16'sh1000; w.dy = 16'sh0001; pending_words.push_back(w);
        w.x = -16'sh7fff; w.dy = 16'sh7fff; pending_words.push_back(w);
        for (int k = 0; k < 1800; k++) begin
            if ($urandom_range(0, 3) == 0) w.x = 16'($urandom);
            else w.x = 16'($signed($urandom_range(0, 12288)) - 6144);
            w.dy = 16'($urandom);
            pending_words.push_back(w);
        end
        stimulus_done = 1'b1;
    end

    // Driver
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == 1) i_rst_n <= 1'b1;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_grads.push_back(predict_grad({i_x_value, i_upstream_grad}));
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    t_word w;
                    w = pending_words.pop_front();
                    i_x_value <= w.x;
                    i_upstream_grad <= w.dy;
                    i_valid <= 1'b1;
                    send_gap <= (cycle_count < 600) ? 0 : pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_grads.size() == 0) begin
                    $error("unexpected word: grad %0d", o_input_grad);
                    mismatches = mismatches + 1;
                end else begin
                    t_grad e;
                    e = expected_grads.pop_front();
                    if (e.grad !== o_input_grad) begin
                        $error("input_grad: expected %0d, got %0d", e.grad, o_input_grad);
                        mismatches = mismatches + 1;
                    end
                    if (e.sat !== o_saturated) begin
                        $error("saturated: expected %0d, got %0d", e.sat, o_saturated);
                        mismatches = mismatches + 1;
                    end
                end
            end
            // long hold-off early on so the pipeline backs up
            if (cycle_count >= 40 && hold_off < HOLD_CYCLES) begin
                hold_off <= hold_off + 1;
                i_ready <= 1'b0;
            end else if (cycle_count < 600) begin
                i_ready <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    // End of run
    initial begin
        wait (stimulus_done);
        while ((pending_words.size() > 0 || i_valid || expected_grads.size() > 0)
               && cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            repeat (20) @(posedge i_clk);
            if (mismatches == 0 && expected_grads.size() == 0)
                $display("end of test: clean");
            else
                $display("end of test: mismatches");
            $finish;
        end
    end
endmodule

FILE: gelu_gradient_unit.f
rtl/core/gelu_grad_pkg.sv
rtl/core/gelu_gradient_unit.sv
bench/tb.sv
